/* hdl/y2r_pkg.sv */
// y2r_pkg: item types, coefficients and control struct for the yuyv to rgb converter
// no dependencies; used by y2r_pixel and yuyv_to_rgb_converter
`default_nettype none

package y2r_pkg;

  localparam int STAGES = 4;
  localparam int SUM_W  = 27;

  localparam logic signed [17:0] COEF_RV = 18'sd91881;
  localparam logic signed [17:0] COEF_GU = 18'sd22544;
  localparam logic signed [17:0] COEF_GV = 18'sd46793;
  localparam logic signed [17:0] COEF_BU = 18'sd116130;
  localparam logic [7:0]         CHROMA_BIAS = 8'd128;
  localparam logic [7:0]         CHAN_MAX    = 8'd255;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } in_t;

  typedef struct packed {
    logic [7:0] first_c0;
    logic [7:0] first_c1;
    logic [7:0] first_c2;
    logic [7:0] second_c0;
    logic [7:0] second_c1;
    logic [7:0] second_c2;
  } out_t;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
  } pixel_t;

  typedef struct packed {
    logic [STAGES-1:0] load;
  } ctl_t;

endpackage

`default_nettype wire

/* hdl/y2r_pixel.sv */
// y2r_pixel: four-stage datapath that turns one luma and the shared chroma into one pixel
// depends on y2r_pkg; stage loads come from the top level
`default_nettype none

module y2r_pixel (
  input  wire logic            clk,
  input  wire y2r_pkg::ctl_t   ctl,
  input  wire logic            mode,
  input  wire logic [7:0]      luma,
  input  wire logic [7:0]      cb,
  input  wire logic [7:0]      cr,
  output y2r_pkg::pixel_t      pixel
);
  import y2r_pkg::*;

  // stage 1: capture and remove chroma bias
  logic              mode1;
  logic [7:0]        y1, u1, v1;
  logic signed [8:0] du1, dv1;

  // stage 2: coefficient products
  logic                    mode2;
  logic [7:0]              y2, u2, v2;
  logic signed [SUM_W-1:0] pbu, pgu, pgv, prv;

  // stage 3: channel sums
  logic                    mode3;
  logic [7:0]              y3, u3, v3;
  logic signed [SUM_W-1:0] sb, sg, sr;

  logic signed [SUM_W-1:0] base2;

  function automatic logic [7:0] sat_floor(input logic signed [SUM_W-1:0] acc);
    logic [7:0] r;
    if (acc[SUM_W-1]) begin
      r = 8'd0;
    end else if (|acc[SUM_W-2:24]) begin
      r = CHAN_MAX;
    end else begin
      r = acc[23:16];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      mode1 <= mode;
      y1    <= luma;
      u1    <= cb;
      v1    <= cr;
      du1   <= $signed({1'b0, cb}) - $signed({1'b0, CHROMA_BIAS});
      dv1   <= $signed({1'b0, cr}) - $signed({1'b0, CHROMA_BIAS});
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      mode2 <= mode1;
      y2    <= y1;
      u2    <= u1;
      v2    <= v1;
      pbu   <= SUM_W'(COEF_BU) * SUM_W'(du1);
      pgu   <= SUM_W'(COEF_GU) * SUM_W'(du1);
      pgv   <= SUM_W'(COEF_GV) * SUM_W'(dv1);
      prv   <= SUM_W'(COEF_RV) * SUM_W'(dv1);
    end
  end

  assign base2 = $signed({3'b000, y2, 16'h0000});

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      mode3 <= mode2;
      y3    <= y2;
      u3    <= u2;
      v3    <= v2;
      sb    <= base2 + pbu;
      sg    <= base2 - pgu - pgv;
      sr    <= base2 + prv;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      if (mode3) begin
        pixel.c0 <= sat_floor(sb);
        pixel.c1 <= sat_floor(sg);
        pixel.c2 <= sat_floor(sr);
      end else begin
        pixel.c0 <= y3;
        pixel.c1 <= u3;
        pixel.c2 <= v3;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/yuyv_to_rgb_converter.sv */
// yuyv_to_rgb_converter: top level, valid/stall handshake, mode register, two pixel datapaths
// depends on y2r_pkg and y2r_pixel
`default_nettype none

// Takes one YUYV macropixel per clock on src while src_stall is low and gives its two
// pixels as B, G, R (BT.601 full range, Q16 coefficients, saturated and floored) or as
// Y, U, V when convert mode is 0. Items pass through a four-stage pipeline (bias,
// multiply, sum, saturate); sustained rate is one item per clock while dst_stall is low.
// Each stage holds its item while the next is full and stalled, so empty slots close up
// and src_stall rises only when all four stages are full. cfg_ready is always high;
// write the mode only while no item is in flight.
module yuyv_to_rgb_converter (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          src_valid,
  output      logic          src_stall,
  input  wire y2r_pkg::in_t  src_item,
  output      logic          dst_valid,
  input  wire logic          dst_stall,
  output      y2r_pkg::out_t dst_item,
  input  wire logic          cfg_valid,
  output      logic          cfg_ready,
  input  wire logic          cfg_data
);
  import y2r_pkg::*;

  logic              convert_mode;
  logic [STAGES-1:0] stage_valid;
  logic [STAGES-1:0] en;
  logic [STAGES-1:0] fill;
  ctl_t              ctl;
  pixel_t            pix_first, pix_second;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      convert_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      convert_mode <= cfg_data;
    end
  end

  always_comb begin
    en[STAGES-1] = !stage_valid[STAGES-1] || !dst_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !stage_valid[k] || en[k+1];
    end
  end

  assign fill = {stage_valid[STAGES-2:0], src_valid};
  assign ctl.load = en & fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (en[k]) begin
          stage_valid[k] <= fill[k];
        end
      end
    end
  end

  assign src_stall = !en[0];
  assign dst_valid = stage_valid[STAGES-1];

  y2r_pixel u_first (
    .clk   (clk),
    .ctl   (ctl),
    .mode  (convert_mode),
    .luma  (src_item.luma_first),
    .cb    (src_item.chroma_blue),
    .cr    (src_item.chroma_red),
    .pixel (pix_first)
  );

  y2r_pixel u_second (
    .clk   (clk),
    .ctl   (ctl),
    .mode  (convert_mode),
    .luma  (src_item.luma_second),
    .cb    (src_item.chroma_blue),
    .cr    (src_item.chroma_red),
    .pixel (pix_second)
  );

  assign dst_item.first_c0  = pix_first.c0;
  assign dst_item.first_c1  = pix_first.c1;
  assign dst_item.first_c2  = pix_first.c2;
  assign dst_item.second_c0 = pix_second.c0;
  assign dst_item.second_c1 = pix_second.c1;
  assign dst_item.second_c2 = pix_second.c2;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> (&stage_valid) && dst_stall)
    else $error("src stalled with a free stage");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> $past(stage_valid[STAGES-2]) || $past(stage_valid[STAGES-1]))
    else $error("output item without a source in the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// testbench for yuyv_to_rgb_converter: a directed table of macropixels, then random bursts,
// run in both modes and checked against table values or a fixed-point bt.601 predictor
// depends on y2r_pkg and yuyv_to_rgb_converter
`timescale 1ns / 1ps

module testbench;

  import y2r_pkg::*;

  localparam longint Q16_RV   = 91881;
  localparam longint Q16_GU   = 22544;
  localparam longint Q16_GV   = 46793;
  localparam longint Q16_BU   = 116130;
  localparam longint UV_BIAS  = 128;
  localparam longint CHAN_TOP = 255 * 65536;
  localparam bit     MODE_PASS    = 1'b0;
  localparam bit     MODE_CONVERT = 1'b1;
  localparam int     NUM_ROWS     = 20;
  localparam int     NUM_PHASES   = 6;
  localparam int     PHASE_ITEMS  = 100;

  typedef struct {
    bit   mode;
    in_t  px;
    bit   known;
    out_t want;
  } dir_row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  src_valid = 1'b0;
  logic  src_stall;
  in_t   src_item = '0;
  logic  dst_valid;
  logic  dst_stall = 1'b0;
  out_t  dst_item;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic  cfg_data = 1'b1;

  bit    conv_mode = MODE_CONVERT;
  out_t  pending_pixels[$];
  int    mismatches = 0;
  int    results_seen = 0;
  int    stall_left = 0;
  int    stall_style = 0;

  bit    phase_modes[NUM_PHASES] = '{MODE_PASS, MODE_CONVERT, MODE_PASS, MODE_CONVERT,
                                     MODE_CONVERT, MODE_PASS};

  dir_row_t dir_rows[NUM_ROWS] = '{
    '{MODE_CONVERT, {8'd0, 8'd128, 8'd255, 8'd128}, 1'b1,
      {8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255}},
    '{MODE_CONVERT, {8'd128, 8'd128, 8'd64, 8'd128}, 1'b1,
      {8'd128, 8'd128, 8'd128, 8'd64, 8'd64, 8'd64}},
    '{MODE_CONVERT, {8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{MODE_CONVERT, {8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{MODE_CONVERT, {8'd0, 8'd255, 8'd255, 8'd0}, 1'b0, '0},
    '{MODE_CONVERT, {8'd255, 8'd0, 8'd0, 8'd255}, 1'b0, '0},
    '{MODE_CONVERT, {8'd16, 8'd90, 8'd235, 8'd240}, 1'b0, '0},
    '{MODE_CONVERT, {8'd200, 8'd10, 8'd30, 8'd245}, 1'b0, '0},
    '{MODE_CONVERT, {8'd100, 8'd128, 8'd100, 8'd0}, 1'b0, '0},
    '{MODE_CONVERT, {8'd100, 8'd0, 8'd100, 8'd128}, 1'b0, '0},
    '{MODE_CONVERT, {8'd1, 8'd127, 8'd254, 8'd129}, 1'b0, '0},
    '{MODE_CONVERT, {8'hAA, 8'h55, 8'h55, 8'hAA}, 1'b0, '0},
    '{MODE_PASS, {8'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '0},
    '{MODE_PASS, {8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, {6{8'd255}}},
    '{MODE_PASS, {8'h12, 8'h34, 8'h56, 8'h78}, 1'b1,
      {8'h12, 8'h34, 8'h78, 8'h56, 8'h34, 8'h78}},
    '{MODE_PASS, {8'hAA, 8'h55, 8'h55, 8'hAA}, 1'b1,
      {8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA}},
    '{MODE_PASS, {8'h01, 8'h80, 8'hFE, 8'h7F}, 1'b1,
      {8'h01, 8'h80, 8'h7F, 8'hFE, 8'h80, 8'h7F}},
    '{MODE_CONVERT, {8'd255, 8'd128, 8'd0, 8'd128}, 1'b1,
      {8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0}},
    '{MODE_CONVERT, {8'd77, 8'd200, 8'd180, 8'd60}, 1'b0, '0},
    '{MODE_CONVERT, {8'd3, 8'd255, 8'd252, 8'd1}, 1'b0, '0}
  };

  yuyv_to_rgb_converter u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL yuyv_to_rgb_converter");
    $finish;
  end

  function automatic logic [7:0] clamp_q16(longint acc);
    if (acc < 0) return 8'd0;
    if (acc > CHAN_TOP) return 8'd255;
    return acc[23:16];
  endfunction

  function automatic pixel_t bt601_pixel(logic [7:0] luma, longint du, longint dv);
    longint base;
    pixel_t p;
    base = longint'(luma) * 65536;
    p.c0 = clamp_q16(base + Q16_BU * du);
    p.c1 = clamp_q16(base - Q16_GU * du - Q16_GV * dv);
    p.c2 = clamp_q16(base + Q16_RV * dv);
    return p;
  endfunction

  function automatic out_t predict_pixels(in_t px, bit mode);
    longint du;
    longint dv;
    if (mode == MODE_PASS)
      return {px.luma_first, px.chroma_blue, px.chroma_red,
              px.luma_second, px.chroma_blue, px.chroma_red};
    du = longint'(px.chroma_blue) - UV_BIAS;
    dv = longint'(px.chroma_red) - UV_BIAS;
    return {bt601_pixel(px.luma_first, du, dv), bt601_pixel(px.luma_second, du, dv)};
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_macropixel(in_t px, bit known, out_t want);
    src_item  <= px;
    src_valid <= 1'b1;
    do @(posedge clk); while (src_stall);
    pending_pixels.push_back(known ? want : predict_pixels(px, conv_mode));
  endtask

  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_mode(bit mode);
    src_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_data  <= mode;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    conv_mode = mode;
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(20, 200);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_style)
      0: dst_stall <= 1'b0;
      1: dst_stall <= ($urandom_range(0, 1) == 0);
      2: dst_stall <= ($urandom_range(0, 3) != 0);
      default: dst_stall <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && dst_valid && !dst_stall) begin
      results_seen = results_seen + 1;
      if (pending_pixels.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected item %0d: actual %p", results_seen, dst_item);
      end else begin
        want = pending_pixels.pop_front();
        if (dst_item.first_c0 !== want.first_c0 || dst_item.first_c1 !== want.first_c1 ||
            dst_item.first_c2 !== want.first_c2 || dst_item.second_c0 !== want.second_c0 ||
            dst_item.second_c1 !== want.second_c1 || dst_item.second_c2 !== want.second_c2) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch item %0d: expected %p actual %p", results_seen, want, dst_item);
        end
      end
    end
  end

  initial begin
    int  burst;
    in_t px;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (dir_rows[r].mode != conv_mode)
        write_mode(dir_rows[r].mode);
      send_macropixel(dir_rows[r].px, dir_rows[r].known, dir_rows[r].want);
      if ($urandom_range(0, 1) == 0)
        idle_gap();
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_mode(phase_modes[ph]);
      burst = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst == 0) begin
          idle_gap();
          burst = $urandom_range(1, 32);
        end
        px = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        send_macropixel(px, 1'b0, '0);
        burst = burst - 1;
      end
    end

    src_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("PASS yuyv_to_rgb_converter");
    end else begin
      $display("FAIL yuyv_to_rgb_converter");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/y2r_pkg.sv
hdl/y2r_pixel.sv
hdl/yuyv_to_rgb_converter.sv
tb/sv/testbench.sv
